// File: design/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, widths and codes of the 2-D k-means clustering unit.
// ----------------------------------------------------------------------------
package kmc_pkg;

    // Sizing
    localparam int MAX_POINTS   = 1024;
    localparam int MAX_CLUSTERS = 10;
    localparam int COORD_BITS   = 16;

    localparam int PT_AW   = $clog2(MAX_POINTS);        // point store address
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);    // point / member count
    localparam int CL_W    = 4;                         // cluster index field
    localparam int FRAC_W  = 8;                         // Q16.8 fraction bits
    localparam int CENT_W  = COORD_BITS + FRAC_W;       // centroid width
    localparam int SUM_W   = COORD_BITS + PT_AW + 1;    // member coordinate sum
    localparam int DIF_W   = CENT_W + 1;                // difference width
    localparam int SQ_W    = 2 * CENT_W;                // square of a difference
    localparam int DIST_W  = SQ_W + 1;                  // sum of two squares
    localparam int ACC_W   = DIST_W + PT_AW + 1;        // error accumulator
    localparam int SSE_W   = 48;                        // reported error
    localparam int SSE_SH  = 2 * FRAC_W;                // error scale shift
    localparam int PASS_W  = 4;
    localparam int CFG_W   = 4;                         // config data width
    localparam int CFG_AW  = 2;                         // config index width
    localparam int DIV_N   = SUM_W + FRAC_W;            // dividend magnitude bits
    localparam int DIV_CW  = $clog2(DIV_N + 1);

    // Configuration
    localparam logic [CFG_AW-1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ITER_LIMIT    = 2'd1;
    localparam logic [CFG_W-1:0]  K_RESET           = 4'd2;
    localparam logic [CFG_W-1:0]  LIMIT_RESET       = 4'd10;
    localparam logic [CFG_W-1:0]  K_MIN             = 4'd2;

    // Result kinds
    localparam logic RK_CENTROID = 1'b0;
    localparam logic RK_SUMMARY  = 1'b1;

    typedef enum logic [1:0] {
        OP_CLEAR        = 2'd0,
        OP_APPEND       = 2'd1,
        OP_SET_CENTROID = 2'd2,
        OP_RUN          = 2'd3
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PASS_INIT,
        S_A_RD,
        S_A_DIFF,
        S_A_SQ,
        S_A_CMP,
        S_A_WR,
        S_UPD_INIT,
        S_U_DIV,
        S_U_WAIT,
        S_U_WR,
        S_PASS_END,
        S_SSE_INIT,
        S_E_RD,
        S_E_DIFF,
        S_E_SQ,
        S_E_ACC,
        S_EMIT,
        S_SUM
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input item taken
        logic run_init;   // latch k and limit, zero pass count
        logic pass_init;  // clear sums and counts, point index to zero
        logic clr_j;      // cluster index to zero
        logic diff;       // form coordinate differences
        logic sq;         // square differences
        logic cmp;        // nearest-centroid compare
        logic inc_j;
        logic inc_i;
        logic wr_label;   // store label, accumulate member sums
        logic div_start;
        logic cent_wr;    // write new centroid
        logic inc_pass;
        logic sse_init;   // zero error accumulator and point index
        logic sse_mode;   // error pass: centroid chosen by stored label
        logic acc;        // accumulate squared error
        logic emit_rep;
        logic emit_sum;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic n_zero;
        logic last_i;
        logic last_j;
        logic div_done;
        logic stop;
        logic out_free;
    } t_sts;

    // Integer part of a Q16.8 value, truncated toward zero
    function automatic logic signed [COORD_BITS:0] f_int_part(
        input logic signed [CENT_W-1:0] c
    );
        logic signed [COORD_BITS:0] fl;
        fl = COORD_BITS'(c[CENT_W-1:FRAC_W]) == '0 ? '0 :
             (COORD_BITS+1)'($signed(c[CENT_W-1:FRAC_W]));
        if (c[CENT_W-1] && (c[FRAC_W-1:0] != '0)) begin
            fl = fl + (COORD_BITS+1)'(1);
        end
        return fl;
    endfunction

endpackage

// File: design/kmc_if.sv
// ----------------------------------------------------------------------------
// kmc_if
// Valid/ready channels of the k-means unit: input items, results, config.
// ----------------------------------------------------------------------------
interface kmc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            opcode;
    logic signed [kmc_pkg::COORD_BITS-1:0] coord_x;
    logic signed [kmc_pkg::COORD_BITS-1:0] coord_y;
    logic [kmc_pkg::CL_W-1:0]              cluster_index;

    modport source (output valid, opcode, coord_x, coord_y, cluster_index,
                    input ready);
    modport sink   (input valid, opcode, coord_x, coord_y, cluster_index,
                    output ready);
endinterface

interface kmc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              result_kind;
    logic [kmc_pkg::CL_W-1:0]          result_cluster;
    logic signed [kmc_pkg::CENT_W-1:0] centroid_x;
    logic signed [kmc_pkg::CENT_W-1:0] centroid_y;
    logic [kmc_pkg::CNT_W-1:0]         members;
    logic [kmc_pkg::SSE_W-1:0]         squared_error;
    logic [kmc_pkg::PASS_W-1:0]        passes_done;
    logic                              last_item;

    modport source (output valid, result_kind, result_cluster, centroid_x,
                    centroid_y, members, squared_error, passes_done, last_item,
                    input ready);
    modport sink   (input valid, result_kind, result_cluster, centroid_x,
                    centroid_y, members, squared_error, passes_done, last_item,
                    output ready);
endinterface

interface kmc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [kmc_pkg::CFG_AW-1:0]  index;
    logic [kmc_pkg::CFG_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/kmeans_cluster_2d_unit.sv
// ----------------------------------------------------------------------------
// kmeans_cluster_2d_unit
// Lloyd k-means over up to 1024 stored 2-D integer points.
// ----------------------------------------------------------------------------
// Clear, append and set-centroid items are accepted back to back. A run item
// holds the input until its last result is loaded: each pass runs the
// assignment (one shared distance unit, one point-centroid pair at a time)
// and then the means (one 35-step serial divider, both axes at once), the
// closing error pass visits each point once, then k+1 result items follow
// at one per cycle when the output is not stalled. Config writes are always
// ready.
module kmeans_cluster_2d_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmc_in_if.sink     i_in_ch,
    kmc_out_if.source  o_out_ch,
    kmc_cfg_if.sink    i_cfg_ch
);

    kmc_pkg::t_cmd w_cmd;
    kmc_pkg::t_sts w_sts;
    logic          w_in_ready;

    assign i_in_ch.ready  = w_in_ready;
    assign i_cfg_ch.ready = 1'b1;

    kmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_opcode   (i_in_ch.opcode),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    kmc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_opcode         (i_in_ch.opcode),
        .i_coord_x        (i_in_ch.coord_x),
        .i_coord_y        (i_in_ch.coord_y),
        .i_cluster_index  (i_in_ch.cluster_index),
        .i_cfg_we         (i_cfg_ch.valid),
        .i_cfg_index      (i_cfg_ch.index),
        .i_cfg_data       (i_cfg_ch.data),
        .i_out_ready      (o_out_ch.ready),
        .o_out_valid      (o_out_ch.valid),
        .o_result_kind    (o_out_ch.result_kind),
        .o_result_cluster (o_out_ch.result_cluster),
        .o_centroid_x     (o_out_ch.centroid_x),
        .o_centroid_y     (o_out_ch.centroid_y),
        .o_members        (o_out_ch.members),
        .o_squared_error  (o_out_ch.squared_error),
        .o_passes_done    (o_out_ch.passes_done),
        .o_last_item      (o_out_ch.last_item)
    );

endmodule

// File: design/kmc_ram.sv
// ----------------------------------------------------------------------------
// kmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/kmc_div.sv
// ----------------------------------------------------------------------------
// kmc_div
// Serial signed divider for the centroid means: (sum * 256) / count, both
// axes at once, one quotient bit per cycle, truncated toward zero.
// ----------------------------------------------------------------------------
module kmc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [kmc_pkg::SUM_W-1:0]  i_num_x,
    input  logic signed [kmc_pkg::SUM_W-1:0]  i_num_y,
    input  logic [kmc_pkg::CNT_W-1:0]         i_den,
    output logic                              o_done,
    output logic signed [kmc_pkg::CENT_W-1:0] o_quot_x,
    output logic signed [kmc_pkg::CENT_W-1:0] o_quot_y
);

    localparam int REM_W = kmc_pkg::CNT_W + 1;

    logic                           r_busy;
    logic                           r_done;
    logic [kmc_pkg::DIV_CW-1:0]     r_cnt;
    logic [kmc_pkg::CNT_W-1:0]      r_den;
    logic                           r_neg_x;
    logic                           r_neg_y;
    logic [kmc_pkg::DIV_N-1:0]      r_q_x;
    logic [kmc_pkg::DIV_N-1:0]      r_q_y;
    logic [REM_W-1:0]               r_rem_x;
    logic [REM_W-1:0]               r_rem_y;
    logic [REM_W-1:0]               w_t_x;
    logic [REM_W-1:0]               w_t_y;
    logic                           w_ge_x;
    logic                           w_ge_y;
    logic [kmc_pkg::DIV_N-1:0]      w_mag_x;
    logic [kmc_pkg::DIV_N-1:0]      w_mag_y;
    logic [kmc_pkg::DIV_N-1:0]      w_res_x;
    logic [kmc_pkg::DIV_N-1:0]      w_res_y;

    // Dividend magnitudes, scaled to unsigned Q27.8
    assign w_mag_x = {(i_num_x[kmc_pkg::SUM_W-1] ? kmc_pkg::SUM_W'(-i_num_x)
                                                 : kmc_pkg::SUM_W'(i_num_x)),
                      kmc_pkg::FRAC_W'(0)};
    assign w_mag_y = {(i_num_y[kmc_pkg::SUM_W-1] ? kmc_pkg::SUM_W'(-i_num_y)
                                                 : kmc_pkg::SUM_W'(i_num_y)),
                      kmc_pkg::FRAC_W'(0)};

    // Restoring step
    assign w_t_x  = {r_rem_x[REM_W-2:0], r_q_x[kmc_pkg::DIV_N-1]};
    assign w_t_y  = {r_rem_y[REM_W-2:0], r_q_y[kmc_pkg::DIV_N-1]};
    assign w_ge_x = w_t_x >= {1'b0, r_den};
    assign w_ge_y = w_t_y >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= kmc_pkg::DIV_CW'(kmc_pkg::DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - kmc_pkg::DIV_CW'(1);
                if (r_cnt == kmc_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den   <= i_den;
            r_neg_x <= i_num_x[kmc_pkg::SUM_W-1];
            r_neg_y <= i_num_y[kmc_pkg::SUM_W-1];
            r_q_x   <= w_mag_x;
            r_q_y   <= w_mag_y;
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (r_busy) begin
            r_rem_x <= w_ge_x ? w_t_x - {1'b0, r_den} : w_t_x;
            r_rem_y <= w_ge_y ? w_t_y - {1'b0, r_den} : w_t_y;
            r_q_x   <= {r_q_x[kmc_pkg::DIV_N-2:0], w_ge_x};
            r_q_y   <= {r_q_y[kmc_pkg::DIV_N-2:0], w_ge_y};
        end
    end

    assign w_res_x  = r_neg_x ? -r_q_x : r_q_x;
    assign w_res_y  = r_neg_y ? -r_q_y : r_q_y;
    assign o_quot_x = $signed(w_res_x[kmc_pkg::CENT_W-1:0]);
    assign o_quot_y = $signed(w_res_y[kmc_pkg::CENT_W-1:0]);
    assign o_done   = r_done;

endmodule

// File: design/kmc_ctrl.sv
// ----------------------------------------------------------------------------
// kmc_ctrl
// Sequencer of the k-means unit: loads, assignment, update and error passes,
// result emission.
// ----------------------------------------------------------------------------
module kmc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_opcode,
    input  kmc_pkg::t_sts  i_sts,
    output logic           o_in_ready,
    output kmc_pkg::t_cmd  o_cmd
);

    kmc_pkg::t_state r_state;
    kmc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmc_pkg::S_IDLE: begin
                if (i_in_valid && (i_opcode == kmc_pkg::OP_RUN)) begin
                    n_state = kmc_pkg::S_PASS_INIT;
                end
            end
            kmc_pkg::S_PASS_INIT: begin
                n_state = i_sts.n_zero ? kmc_pkg::S_UPD_INIT : kmc_pkg::S_A_RD;
            end
            kmc_pkg::S_A_RD:   n_state = kmc_pkg::S_A_DIFF;
            kmc_pkg::S_A_DIFF: n_state = kmc_pkg::S_A_SQ;
            kmc_pkg::S_A_SQ:   n_state = kmc_pkg::S_A_CMP;
            kmc_pkg::S_A_CMP: begin
                n_state = i_sts.last_j ? kmc_pkg::S_A_WR : kmc_pkg::S_A_DIFF;
            end
            kmc_pkg::S_A_WR: begin
                n_state = i_sts.last_i ? kmc_pkg::S_UPD_INIT : kmc_pkg::S_A_RD;
            end
            kmc_pkg::S_UPD_INIT: n_state = kmc_pkg::S_U_DIV;
            kmc_pkg::S_U_DIV:    n_state = kmc_pkg::S_U_WAIT;
            kmc_pkg::S_U_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = kmc_pkg::S_U_WR;
                end
            end
            kmc_pkg::S_U_WR: begin
                n_state = i_sts.last_j ? kmc_pkg::S_PASS_END : kmc_pkg::S_U_DIV;
            end
            kmc_pkg::S_PASS_END: begin
                n_state = i_sts.stop ? kmc_pkg::S_SSE_INIT : kmc_pkg::S_PASS_INIT;
            end
            kmc_pkg::S_SSE_INIT: begin
                n_state = i_sts.n_zero ? kmc_pkg::S_EMIT : kmc_pkg::S_E_RD;
            end
            kmc_pkg::S_E_RD:   n_state = kmc_pkg::S_E_DIFF;
            kmc_pkg::S_E_DIFF: n_state = kmc_pkg::S_E_SQ;
            kmc_pkg::S_E_SQ:   n_state = kmc_pkg::S_E_ACC;
            kmc_pkg::S_E_ACC: begin
                n_state = i_sts.last_i ? kmc_pkg::S_EMIT : kmc_pkg::S_E_RD;
            end
            kmc_pkg::S_EMIT: begin
                if (i_sts.out_free && i_sts.last_j) begin
                    n_state = kmc_pkg::S_SUM;
                end
            end
            kmc_pkg::S_SUM: begin
                if (i_sts.out_free) begin
                    n_state = kmc_pkg::S_IDLE;
                end
            end
            default: n_state = kmc_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            kmc_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.accept   = i_in_valid;
                o_cmd.run_init = i_in_valid && (i_opcode == kmc_pkg::OP_RUN);
            end
            kmc_pkg::S_PASS_INIT: o_cmd.pass_init = 1'b1;
            kmc_pkg::S_A_RD:      o_cmd.clr_j     = 1'b1;
            kmc_pkg::S_A_DIFF:    o_cmd.diff      = 1'b1;
            kmc_pkg::S_A_SQ:      o_cmd.sq        = 1'b1;
            kmc_pkg::S_A_CMP: begin
                o_cmd.cmp   = 1'b1;
                o_cmd.inc_j = !i_sts.last_j;
            end
            kmc_pkg::S_A_WR: begin
                o_cmd.wr_label = 1'b1;
                o_cmd.inc_i    = !i_sts.last_i;
            end
            kmc_pkg::S_UPD_INIT: o_cmd.clr_j     = 1'b1;
            kmc_pkg::S_U_DIV:    o_cmd.div_start = 1'b1;
            kmc_pkg::S_U_WAIT:   o_cmd           = '0;
            kmc_pkg::S_U_WR: begin
                o_cmd.cent_wr = 1'b1;
                o_cmd.inc_j   = !i_sts.last_j;
            end
            kmc_pkg::S_PASS_END: o_cmd.inc_pass = 1'b1;
            kmc_pkg::S_SSE_INIT: begin
                o_cmd.sse_init = 1'b1;
                o_cmd.clr_j    = 1'b1;
            end
            kmc_pkg::S_E_RD:   o_cmd.sse_mode = 1'b1;
            kmc_pkg::S_E_DIFF: begin
                o_cmd.sse_mode = 1'b1;
                o_cmd.diff     = 1'b1;
            end
            kmc_pkg::S_E_SQ: begin
                o_cmd.sse_mode = 1'b1;
                o_cmd.sq       = 1'b1;
            end
            kmc_pkg::S_E_ACC: begin
                o_cmd.sse_mode = 1'b1;
                o_cmd.acc      = 1'b1;
                o_cmd.inc_i    = !i_sts.last_i;
            end
            kmc_pkg::S_EMIT: begin
                o_cmd.emit_rep = i_sts.out_free;
                o_cmd.inc_j    = i_sts.out_free && !i_sts.last_j;
            end
            kmc_pkg::S_SUM: o_cmd.emit_sum = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: design/kmc_dp.sv
// ----------------------------------------------------------------------------
// kmc_dp
// Datapath of the k-means unit: point and label stores, centroids, member
// sums, distance and error arithmetic, config registers and result register.
// ----------------------------------------------------------------------------
module kmc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  kmc_pkg::t_cmd                      i_cmd,
    output kmc_pkg::t_sts                      o_sts,
    // input item payload
    input  logic [1:0]                         i_opcode,
    input  logic signed [kmc_pkg::COORD_BITS-1:0] i_coord_x,
    input  logic signed [kmc_pkg::COORD_BITS-1:0] i_coord_y,
    input  logic [kmc_pkg::CL_W-1:0]           i_cluster_index,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [kmc_pkg::CFG_AW-1:0]         i_cfg_index,
    input  logic [kmc_pkg::CFG_W-1:0]          i_cfg_data,
    // result channel
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_result_kind,
    output logic [kmc_pkg::CL_W-1:0]           o_result_cluster,
    output logic signed [kmc_pkg::CENT_W-1:0]  o_centroid_x,
    output logic signed [kmc_pkg::CENT_W-1:0]  o_centroid_y,
    output logic [kmc_pkg::CNT_W-1:0]          o_members,
    output logic [kmc_pkg::SSE_W-1:0]          o_squared_error,
    output logic [kmc_pkg::PASS_W-1:0]         o_passes_done,
    output logic                               o_last_item
);

    localparam int CB = kmc_pkg::COORD_BITS;

    // Config and run control
    logic [kmc_pkg::CFG_W-1:0]   r_cfg_k;
    logic [kmc_pkg::CFG_W-1:0]   r_cfg_lim;
    logic [kmc_pkg::CL_W-1:0]    r_k;
    logic [kmc_pkg::PASS_W-1:0]  r_limit;
    logic [kmc_pkg::PASS_W-1:0]  r_pass;
    logic                        r_moved;
    logic [kmc_pkg::CNT_W-1:0]   r_n;
    logic [kmc_pkg::PT_AW-1:0]   r_i;
    logic [kmc_pkg::CL_W-1:0]    r_j;

    // Cluster state
    logic signed [kmc_pkg::CENT_W-1:0] r_cx    [kmc_pkg::MAX_CLUSTERS];
    logic signed [kmc_pkg::CENT_W-1:0] r_cy    [kmc_pkg::MAX_CLUSTERS];
    logic signed [kmc_pkg::SUM_W-1:0]  r_sum_x [kmc_pkg::MAX_CLUSTERS];
    logic signed [kmc_pkg::SUM_W-1:0]  r_sum_y [kmc_pkg::MAX_CLUSTERS];
    logic [kmc_pkg::CNT_W-1:0]         r_cnt   [kmc_pkg::MAX_CLUSTERS];

    // Arithmetic registers
    logic signed [kmc_pkg::DIF_W-1:0]  r_dx;
    logic signed [kmc_pkg::DIF_W-1:0]  r_dy;
    logic [kmc_pkg::SQ_W-1:0]          r_sqx;
    logic [kmc_pkg::SQ_W-1:0]          r_sqy;
    logic [kmc_pkg::DIST_W-1:0]        r_best;
    logic [kmc_pkg::CL_W-1:0]          r_pick;
    logic [kmc_pkg::ACC_W-1:0]         r_acc;

    // Result register
    logic                              r_out_valid;
    logic                              r_kind;
    logic [kmc_pkg::CL_W-1:0]          r_rcl;
    logic signed [kmc_pkg::CENT_W-1:0] r_ocx;
    logic signed [kmc_pkg::CENT_W-1:0] r_ocy;
    logic [kmc_pkg::CNT_W-1:0]         r_omem;
    logic [kmc_pkg::SSE_W-1:0]         r_osse;
    logic [kmc_pkg::PASS_W-1:0]        r_opass;
    logic                              r_olast;

    // Combinational
    logic                              w_pt_we;
    logic [2*CB-1:0]                   w_pt_rd;
    logic [kmc_pkg::CL_W-1:0]          w_lbl;
    logic signed [CB-1:0]              w_px;
    logic signed [CB-1:0]              w_py;
    logic [kmc_pkg::CL_W-1:0]          w_cidx;
    logic signed [kmc_pkg::CENT_W-1:0] w_ccx;
    logic signed [kmc_pkg::CENT_W-1:0] w_ccy;
    logic signed [2*kmc_pkg::DIF_W-1:0] w_mx;
    logic signed [2*kmc_pkg::DIF_W-1:0] w_my;
    logic [kmc_pkg::DIST_W-1:0]        w_dist;
    logic                              w_div_done;
    logic signed [kmc_pkg::CENT_W-1:0] w_qx;
    logic signed [kmc_pkg::CENT_W-1:0] w_qy;
    logic signed [kmc_pkg::CENT_W-1:0] w_nx;
    logic signed [kmc_pkg::CENT_W-1:0] w_ny;
    logic [kmc_pkg::CL_W-1:0]          w_k_clamp;
    logic [kmc_pkg::ACC_W-1:0]         w_sse_sh;

    // Point store, x in the low half
    assign w_pt_we = i_cmd.accept && (i_opcode == kmc_pkg::OP_APPEND) &&
                     (r_n < kmc_pkg::CNT_W'(kmc_pkg::MAX_POINTS));

    kmc_ram #(
        .WIDTH (2 * CB),
        .DEPTH (kmc_pkg::MAX_POINTS)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (r_n[kmc_pkg::PT_AW-1:0]),
        .i_wdata ({i_coord_y, i_coord_x}),
        .i_raddr (r_i),
        .o_rdata (w_pt_rd)
    );

    kmc_ram #(
        .WIDTH (kmc_pkg::CL_W),
        .DEPTH (kmc_pkg::MAX_POINTS)
    ) u_lbl_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_label),
        .i_waddr (r_i),
        .i_wdata (r_pick),
        .i_raddr (r_i),
        .o_rdata (w_lbl)
    );

    assign w_px = $signed(w_pt_rd[CB-1:0]);
    assign w_py = $signed(w_pt_rd[2*CB-1:CB]);

    // Centroid read port: loop index, or stored label in the error pass
    assign w_cidx = i_cmd.sse_mode ? w_lbl : r_j;
    always_comb begin
        w_ccx = '0;
        w_ccy = '0;
        if (w_cidx < kmc_pkg::CL_W'(kmc_pkg::MAX_CLUSTERS)) begin
            w_ccx = r_cx[w_cidx];
            w_ccy = r_cy[w_cidx];
        end
    end

    // Squares and distance
    assign w_mx   = r_dx * r_dx;
    assign w_my   = r_dy * r_dy;
    assign w_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

    // Mean divider
    kmc_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_num_x  (r_sum_x[r_j]),
        .i_num_y  (r_sum_y[r_j]),
        .i_den    (r_cnt[r_j]),
        .o_done   (w_div_done),
        .o_quot_x (w_qx),
        .o_quot_y (w_qy)
    );

    assign w_nx = (r_cnt[r_j] == '0) ? '0 : w_qx;
    assign w_ny = (r_cnt[r_j] == '0) ? '0 : w_qy;

    // k clamped to the supported range
    always_comb begin
        if (r_cfg_k < kmc_pkg::K_MIN) begin
            w_k_clamp = kmc_pkg::K_MIN;
        end else if (r_cfg_k > kmc_pkg::CL_W'(kmc_pkg::MAX_CLUSTERS)) begin
            w_k_clamp = kmc_pkg::CL_W'(kmc_pkg::MAX_CLUSTERS);
        end else begin
            w_k_clamp = r_cfg_k;
        end
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_k   <= kmc_pkg::K_RESET;
            r_cfg_lim <= kmc_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kmc_pkg::CFG_CLUSTER_COUNT: r_cfg_k   <= i_cfg_data;
                kmc_pkg::CFG_ITER_LIMIT:    r_cfg_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Point count, centroids, pass control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_pass <= '0;
            for (int c = 0; c < kmc_pkg::MAX_CLUSTERS; c++) begin
                r_cx[c] <= '0;
                r_cy[c] <= '0;
            end
        end else begin
            if (i_cmd.accept) begin
                unique case (kmc_pkg::t_op'(i_opcode))
                    kmc_pkg::OP_CLEAR:  r_n <= '0;
                    kmc_pkg::OP_APPEND: begin
                        if (w_pt_we) begin
                            r_n <= r_n + kmc_pkg::CNT_W'(1);
                        end
                    end
                    kmc_pkg::OP_SET_CENTROID: begin
                        if (i_cluster_index < kmc_pkg::CL_W'(kmc_pkg::MAX_CLUSTERS)) begin
                            r_cx[i_cluster_index] <= {i_coord_x, kmc_pkg::FRAC_W'(0)};
                            r_cy[i_cluster_index] <= {i_coord_y, kmc_pkg::FRAC_W'(0)};
                        end
                    end
                    kmc_pkg::OP_RUN: r_pass <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.cent_wr) begin
                r_cx[r_j] <= w_nx;
                r_cy[r_j] <= w_ny;
            end
            if (i_cmd.inc_pass) begin
                r_pass <= r_pass + kmc_pkg::PASS_W'(1);
            end
        end
    end

    // Run parameters, loop indexes, sums, moved flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_k     <= w_k_clamp;
            r_limit <= (r_cfg_lim == '0) ? kmc_pkg::PASS_W'(1) : r_cfg_lim;
        end
        if (i_cmd.pass_init || i_cmd.sse_init) begin
            r_i <= '0;
        end else if (i_cmd.inc_i) begin
            r_i <= r_i + kmc_pkg::PT_AW'(1);
        end
        if (i_cmd.clr_j) begin
            r_j <= '0;
        end else if (i_cmd.inc_j) begin
            r_j <= r_j + kmc_pkg::CL_W'(1);
        end
        if (i_cmd.pass_init) begin
            r_moved <= 1'b0;
            for (int c = 0; c < kmc_pkg::MAX_CLUSTERS; c++) begin
                r_sum_x[c] <= '0;
                r_sum_y[c] <= '0;
                r_cnt[c]   <= '0;
            end
        end else if (i_cmd.wr_label) begin
            r_sum_x[r_pick] <= r_sum_x[r_pick] + kmc_pkg::SUM_W'(w_px);
            r_sum_y[r_pick] <= r_sum_y[r_pick] + kmc_pkg::SUM_W'(w_py);
            r_cnt[r_pick]   <= r_cnt[r_pick] + kmc_pkg::CNT_W'(1);
        end
        if (i_cmd.cent_wr && ((w_nx != r_cx[r_j]) || (w_ny != r_cy[r_j]))) begin
            r_moved <= 1'b1;
        end
    end

    // Differences, squares, nearest pick, error accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.diff) begin
            if (i_cmd.sse_mode) begin
                r_dx <= kmc_pkg::DIF_W'($signed({w_px, kmc_pkg::FRAC_W'(0)}))
                        - kmc_pkg::DIF_W'(w_ccx);
                r_dy <= kmc_pkg::DIF_W'($signed({w_py, kmc_pkg::FRAC_W'(0)}))
                        - kmc_pkg::DIF_W'(w_ccy);
            end else begin
                r_dx <= kmc_pkg::DIF_W'(w_px) - kmc_pkg::DIF_W'(kmc_pkg::f_int_part(w_ccx));
                r_dy <= kmc_pkg::DIF_W'(w_py) - kmc_pkg::DIF_W'(kmc_pkg::f_int_part(w_ccy));
            end
        end
        if (i_cmd.sq) begin
            r_sqx <= w_mx[kmc_pkg::SQ_W-1:0];
            r_sqy <= w_my[kmc_pkg::SQ_W-1:0];
        end
        // ties keep the lower index
        if (i_cmd.cmp && ((r_j == '0) || (w_dist < r_best))) begin
            r_best <= w_dist;
            r_pick <= r_j;
        end
        if (i_cmd.sse_init) begin
            r_acc <= '0;
        end else if (i_cmd.acc) begin
            r_acc <= r_acc + kmc_pkg::ACC_W'(w_dist);
        end
    end

    assign w_sse_sh = r_acc >> kmc_pkg::SSE_SH;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_rep || i_cmd.emit_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_rep) begin
            r_kind  <= kmc_pkg::RK_CENTROID;
            r_rcl   <= r_j;
            r_ocx   <= w_ccx;
            r_ocy   <= w_ccy;
            r_omem  <= r_cnt[r_j];
            r_osse  <= '0;
            r_opass <= '0;
            r_olast <= 1'b0;
        end else if (i_cmd.emit_sum) begin
            r_kind  <= kmc_pkg::RK_SUMMARY;
            r_rcl   <= '0;
            r_ocx   <= '0;
            r_ocy   <= '0;
            r_omem  <= '0;
            r_osse  <= w_sse_sh[kmc_pkg::SSE_W-1:0];
            r_opass <= r_pass;
            r_olast <= 1'b1;
        end
    end

    // Status
    assign o_sts.n_zero   = (r_n == '0);
    assign o_sts.last_i   = ((kmc_pkg::CNT_W'(r_i) + kmc_pkg::CNT_W'(1)) == r_n);
    assign o_sts.last_j   = (r_j == (r_k - kmc_pkg::CL_W'(1)));
    assign o_sts.div_done = w_div_done;
    assign o_sts.stop     = !r_moved ||
                            (({1'b0, r_pass} + (kmc_pkg::PASS_W+1)'(1)) >= {1'b0, r_limit});
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_result_cluster = r_rcl;
    assign o_centroid_x     = r_ocx;
    assign o_centroid_y     = r_ocy;
    assign o_members        = r_omem;
    assign o_squared_error  = r_osse;
    assign o_passes_done    = r_opass;
    assign o_last_item      = r_olast;

endmodule

// File: design/kmc_checker.sv
// ----------------------------------------------------------------------------
// kmc_checker
// Port-level checks of the k-means unit, bound to the top level.
// ----------------------------------------------------------------------------
module kmc_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic [1:0]               i_opcode,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic                     i_kind,
    input logic [kmc_pkg::CL_W-1:0] i_cluster,
    input logic                     i_last
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) &&
        $stable(i_cluster) && $stable(i_last))
        else $error("result changed while stalled");

    // A run blocks further input
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_opcode == kmc_pkg::OP_RUN) |=> !i_in_ready)
        else $error("input taken during a run");

    // Load items do not block
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_opcode != kmc_pkg::OP_RUN) |=> i_in_ready)
        else $error("load item stalled input");

    // Summary closes the run, reports do not
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == i_last) && (!i_kind || (i_cluster == '0)))
        else $error("bad last marker");

endmodule

bind kmeans_cluster_2d_unit kmc_checker u_kmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_opcode    (i_in_ch.opcode),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_kind      (o_out_ch.result_kind),
    .i_cluster   (o_out_ch.result_cluster),
    .i_last      (o_out_ch.last_item)
);
